// File: rtl/core/dfq_pkg.sv
// dfq_pkg: sizes, command and status codes, and the result record shared
// by the duplicate-rejecting queue and its checker. No dependencies.
`default_nettype none

package dfq_pkg;

  localparam int DEPTH      = 16;
  localparam int ITEM_W     = 32;
  localparam int POS_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the ports
  localparam int CMD_W      = 2;
  localparam int VAL_W      = 32;
  localparam int RPOS_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int DATA_W     = 32;
  localparam int FPOS_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int CAP_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_FIND = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_BADPOS   = 3'd5
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   data;
    logic [FPOS_W-1:0]   fpos;
    logic                found;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/dedup_fifo_queue.sv
// dedup_fifo_queue: first-in first-out queue that refuses values it holds.
// Depends on dfq_pkg, dfq_cell and dfq_out_reg.
//
// Usage
//   Command channel (cmd_valid/cmd_stall) carries cmd, item_value and
//   read_position. Result channel (res_valid/res_stall) carries status,
//   data_out, found_position, found and entry_count.
//   Configuration channel (cfg_valid/cfg_ready, cfg_data) writes the
//   capacity limit; cfg_ready is always high. Write only while idle.
// Timing
//   Each command is worked in the cycle it is accepted: every cell
//   compares its entry with item_value at once, and a dequeue moves every
//   entry one cell down the row. The result appears in the output register
//   in the cycle after acceptance. One command per cycle while results are
//   taken.
// Reset
//   Queue empty, capacity limit 16, no result pending.
// Stall
//   A stalled result holds; the command channel stalls only while a result
//   is held and stalled, so at most one item waits.
`default_nettype none

module dedup_fifo_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_stall,
  input  wire logic [dfq_pkg::CMD_W-1:0]     cmd,
  input  wire logic [dfq_pkg::VAL_W-1:0]     item_value,
  input  wire logic [dfq_pkg::RPOS_W-1:0]    read_position,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic      [dfq_pkg::STATUS_W-1:0]  status,
  output logic      [dfq_pkg::DATA_W-1:0]    data_out,
  output logic      [dfq_pkg::FPOS_W-1:0]    found_position,
  output logic                               found,
  output logic      [dfq_pkg::COUNT_W-1:0]   entry_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dfq_pkg::CAP_W-1:0]     cfg_data
);
  import dfq_pkg::*;

  logic [CAP_W-1:0]   capacity_limit;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   limit;
  logic               accept;
  logic               busy;
  logic [ITEM_W-1:0]  key;
  logic [ITEM_W-1:0]  cell_value [DEPTH];
  logic [DEPTH-1:0]   cell_hit;
  logic [DEPTH-1:0]   hit_vec;
  logic [DEPTH-1:0]   load_vec;
  logic               shift_en;
  logic               any_hit;
  logic [POS_W-1:0]   hit_pos;
  logic               read_ok;
  cmd_t               op;
  res_t               res_d;
  res_t               res_q;

  assign cfg_ready = 1'b1;
  assign cmd_stall = busy;
  assign accept    = cmd_valid && !busy;
  assign key       = ITEM_W'(item_value);
  assign op        = cmd_t'(cmd);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_limit <= cfg_data;
    end
  end

  always_comb begin
    if (CNT_W'(capacity_limit) > CNT_W'(DEPTH)) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(capacity_limit);
    end
  end

  // Row of cells; each hands its entry down on a dequeue
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_W-1:0] up;
    if (i == DEPTH - 1) begin : g_top
      assign up = '0;
    end else begin : g_mid
      assign up = cell_value[i+1];
    end

    dfq_cell u_cell (
      .clk        (clk),
      .shift_en   (shift_en),
      .load_en    (load_vec[i]),
      .neighbour  (up),
      .load_value (key),
      .cmp_value  (key),
      .value      (cell_value[i]),
      .hit        (cell_hit[i])
    );

    assign hit_vec[i] = cell_hit[i] && (CNT_W'(i) < count);
  end

  // Highest matching slot
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) begin
        hit_pos = POS_W'(i);
      end
    end
  end

  assign any_hit = |hit_vec;
  assign read_ok = (CNT_W'(read_position) < count) && (32'(read_position) < DEPTH);

  always_comb begin
    res_d      = '0;
    res_d.status = ST_OK;
    count_next = count;
    shift_en   = 1'b0;
    load_vec   = '0;
    case (op)
      CMD_ENQ: begin
        if (count >= limit) begin
          res_d.status = ST_FULL;
        end else if (any_hit) begin
          res_d.status = ST_DUP;
          res_d.found  = 1'b1;
          res_d.fpos   = FPOS_W'(hit_pos);
        end else begin
          load_vec[POS_W'(count)] = accept;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DEQ: begin
        if (count == '0) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.data = DATA_W'(cell_value[0]);
          shift_en   = accept;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_FIND: begin
        if (any_hit) begin
          res_d.found = 1'b1;
          res_d.fpos  = FPOS_W'(hit_pos);
        end else begin
          res_d.status = ST_NOTFOUND;
        end
      end
      CMD_READ: begin
        if (read_ok) begin
          res_d.data = DATA_W'(cell_value[POS_W'(read_position)]);
        end else begin
          res_d.status = ST_BADPOS;
        end
      end
      default: begin
        res_d.status = ST_OK;
      end
    endcase
    res_d.count = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  dfq_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_in    (res_d),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_out   (res_q),
    .busy      (busy)
  );

  assign status         = res_q.status;
  assign data_out       = res_q.data;
  assign found_position = res_q.fpos;
  assign found          = res_q.found;
  assign entry_count    = res_q.count;

endmodule

`default_nettype wire

// File: rtl/core/dfq_cell.sv
// dfq_cell: one queue slot. Holds an entry, compares it with the search
// value and takes its upper neighbour's entry on a dequeue. Uses dfq_pkg.
`default_nettype none

module dfq_cell (
  input  wire logic                      clk,
  input  wire logic                      shift_en,
  input  wire logic                      load_en,
  input  wire logic [dfq_pkg::ITEM_W-1:0] neighbour,
  input  wire logic [dfq_pkg::ITEM_W-1:0] load_value,
  input  wire logic [dfq_pkg::ITEM_W-1:0] cmp_value,
  output logic      [dfq_pkg::ITEM_W-1:0] value,
  output logic                           hit
);
  import dfq_pkg::*;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      value <= neighbour;
    end else if (load_en) begin
      value <= load_value;
    end
  end

  assign hit = (value == cmp_value);

endmodule

`default_nettype wire

// File: rtl/core/dfq_out_reg.sv
// dfq_out_reg: result register between the queue logic and the result
// channel; takes a new item whenever the held one is gone. Uses dfq_pkg.
`default_nettype none

module dfq_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire dfq_pkg::res_t res_in,
  input  wire logic          res_stall,
  output logic               res_valid,
  output dfq_pkg::res_t      res_out,
  output logic               busy
);
  import dfq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

  // Full and not being taken this cycle
  assign busy = res_valid && res_stall;

endmodule

`default_nettype wire

// File: rtl/core/dfq_checker.sv
// dfq_checker: port-level checks on dedup_fifo_queue, attached by bind.
// Depends on dfq_pkg and the top-level port list.
`default_nettype none

module dfq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cmd_valid,
  input wire logic                          cmd_stall,
  input wire logic                          res_valid,
  input wire logic                          res_stall,
  input wire logic [dfq_pkg::STATUS_W-1:0]  status,
  input wire logic [dfq_pkg::DATA_W-1:0]    data_out,
  input wire logic                          found,
  input wire logic [dfq_pkg::COUNT_W-1:0]   entry_count
);
  import dfq_pkg::*;

  // Accepted item shows up as a result next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> res_valid)
    else $error("accepted item gave no result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(data_out) && $stable(entry_count))
    else $error("stalled result changed");

  a_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> entry_count <= COUNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_nodata: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_FULL || status == ST_EMPTY || status == ST_NOTFOUND ||
                  status == ST_BADPOS) |-> data_out == '0 && !found)
    else $error("failed command carried data");

  a_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && found |-> status == ST_OK || status == ST_DUP)
    else $error("found with a failing status");

endmodule

bind dedup_fifo_queue dfq_checker u_dfq_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd_valid),
  .cmd_stall   (cmd_stall),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .status      (status),
  .data_out    (data_out),
  .found       (found),
  .entry_count (entry_count)
);

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for dedup_fifo_queue. A clocked driver feeds
// commands from a pending queue, a clocked monitor checks every result
// against an in-bench queue model. Depends on dfq_pkg and the block itself.
`default_nettype none

module tb_top;
  import dfq_pkg::*;

  typedef struct {
    cmd_t                op;
    logic [VAL_W-1:0]    val;
    logic [RPOS_W-1:0]   pos;
  } cmd_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  wire                   cmd_stall;
  logic [CMD_W-1:0]      cmd = '0;
  logic [VAL_W-1:0]      item_value = '0;
  logic [RPOS_W-1:0]     read_position = '0;
  wire                   res_valid;
  logic                  res_stall = 1'b0;
  wire  [STATUS_W-1:0]   status;
  wire  [DATA_W-1:0]     data_out;
  wire  [FPOS_W-1:0]     found_position;
  wire                   found;
  wire  [COUNT_W-1:0]    entry_count;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CAP_W-1:0]      cfg_data = '0;

  // queue model state
  logic [VAL_W-1:0]      held_val [DEPTH];
  int                    held_n = 0;
  logic [CAP_W-1:0]      cap_lim = CAP_RESET;

  cmd_item_t             pending [$];
  res_t                  res_due [$];
  cmd_item_t             drv_next;
  res_t                  drv_exp;
  res_t                  mon_want;
  int                    pushed = 0;
  int                    accepted = 0;
  int                    n_results = 0;
  int                    n_errors = 0;
  bit                    no_idle = 1'b0;
  bit                    hold_req = 1'b0;
  bit                    hold_done = 1'b0;
  int                    hold_cycles = 0;

  dedup_fifo_queue dut (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .cmd            (cmd),
    .item_value     (item_value),
    .read_position  (read_position),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .status         (status),
    .data_out       (data_out),
    .found_position (found_position),
    .found          (found),
    .entry_count    (entry_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the result of one command and updates the model queue.
  function automatic res_t dedup_predict(input cmd_t op, input logic [VAL_W-1:0] v,
                                         input logic [RPOS_W-1:0] p);
    res_t r;
    int   lim;
    int   hit_at;
    bit   hit;
    lim = (cap_lim > DEPTH) ? DEPTH : int'(cap_lim);
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    hit_at = 0;
    for (int i = 0; i < held_n; i++) begin
      if (held_val[i] == v) begin
        hit = 1'b1;
        hit_at = i;
      end
    end
    case (op)
      CMD_ENQ: begin
        // full wins over duplicate
        if (held_n >= lim) begin
          r.status = ST_FULL;
        end else if (hit) begin
          r.status = ST_DUP;
          r.found = 1'b1;
          r.fpos = FPOS_W'(hit_at);
        end else begin
          held_val[held_n] = v;
          held_n++;
        end
      end
      CMD_DEQ: begin
        if (held_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = held_val[0];
          for (int i = 0; i + 1 < held_n; i++) held_val[i] = held_val[i + 1];
          held_n--;
        end
      end
      CMD_FIND: begin
        if (hit) begin
          r.found = 1'b1;
          r.fpos = FPOS_W'(hit_at);
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      default: begin
        if (int'(p) >= held_n) r.status = ST_BADPOS;
        else r.data = held_val[p];
      end
    endcase
    r.count = COUNT_W'(held_n);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s got %0h, expected %0h", n_results, field, got, want);
    n_errors++;
  endtask

  // Driver: loads the next item when the slot is free, predicts on accept.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        drv_exp = dedup_predict(cmd_t'(cmd), item_value, read_position);
        res_due.push_back(drv_exp);
        accepted <= accepted + 1;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (pending.size() != 0 && (no_idle || $urandom_range(99) >= 11)) begin
          drv_next = pending.pop_front();
          cmd_valid <= 1'b1;
          cmd <= drv_next.op;
          item_value <= drv_next.val;
          read_position <= drv_next.pos;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random gaps, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_cycles != 0) begin
      res_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req && !hold_done) begin
      res_stall <= 1'b1;
      hold_cycles <= 80;
      hold_done <= 1'b1;
    end else begin
      res_stall <= !no_idle && ($urandom_range(99) < 11);
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (res_due.size() == 0) begin
        report_mismatch("unexpected item, status", 32'(status), 32'(0));
      end else begin
        mon_want = res_due.pop_front();
        if (status !== mon_want.status)
          report_mismatch("status", 32'(status), 32'(mon_want.status));
        if (data_out !== mon_want.data)
          report_mismatch("data_out", 32'(data_out), 32'(mon_want.data));
        if (found_position !== mon_want.fpos)
          report_mismatch("found_position", 32'(found_position), 32'(mon_want.fpos));
        if (found !== mon_want.found)
          report_mismatch("found", 32'(found), 32'(mon_want.found));
        if (entry_count !== mon_want.count)
          report_mismatch("entry_count", 32'(entry_count), 32'(mon_want.count));
      end
      n_results++;
    end
  end

  task automatic add_item(input cmd_t op, input logic [VAL_W-1:0] v,
                          input logic [RPOS_W-1:0] p);
    cmd_item_t it;
    it.op = op;
    it.val = v;
    it.pos = p;
    pending.push_back(it);
    pushed++;
  endtask

  // Waits until every item is in and every result out before returning.
  task automatic drain();
    while (accepted != pushed || res_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_W-1:0] v);
    drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_lim = v;
  endtask

  // Runs of fill-heavy and drain-heavy traffic over a small value pool,
  // so duplicates, hits and the full state come up often.
  task automatic gen_phase(input int n);
    logic [VAL_W-1:0] pool [24];
    bit               filling;
    int               run_left;
    int               roll;
    cmd_t             op;
    logic [VAL_W-1:0] v;
    foreach (pool[k]) pool[k] = $urandom;
    pool[0] = '0;
    pool[1] = '1;
    filling = 1'b1;
    run_left = $urandom_range(24, 8);
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        filling = !filling;
        run_left = $urandom_range(24, 8);
      end
      run_left--;
      roll = $urandom_range(99);
      if (roll < 8)
        op = cmd_t'($urandom_range(3));
      else if (filling)
        op = roll < 60 ? CMD_ENQ : roll < 70 ? CMD_DEQ : roll < 85 ? CMD_FIND : CMD_READ;
      else
        op = roll < 20 ? CMD_ENQ : roll < 65 ? CMD_DEQ : roll < 82 ? CMD_FIND : CMD_READ;
      v = ($urandom_range(99) < 85) ? pool[$urandom_range(23)] : VAL_W'($urandom);
      add_item(op, v, RPOS_W'($urandom_range(15)));
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_cap [8];
    phase_cap[0] = CAP_W'(16);
    phase_cap[1] = CAP_W'(31);
    phase_cap[2] = CAP_W'(4);
    phase_cap[3] = CAP_W'(1);
    phase_cap[4] = CAP_W'(8);
    phase_cap[5] = CAP_W'(0);
    phase_cap[6] = CAP_W'(17);
    phase_cap[7] = CAP_W'($urandom_range(16, 1));
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty queue, extremes of value and position, duplicate, misses
    @(negedge clk);
    add_item(CMD_DEQ,  '0, '0);
    add_item(CMD_FIND, '0, '0);
    add_item(CMD_READ, '0, '0);
    add_item(CMD_ENQ,  '0, '1);
    add_item(CMD_ENQ,  '1, '0);
    add_item(CMD_ENQ,  '0, '0);
    add_item(CMD_FIND, '1, '0);
    add_item(CMD_FIND, 32'h5a5a_a5a5, '0);
    add_item(CMD_READ, '0, 4'd1);
    add_item(CMD_READ, '0, 4'd2);
    add_item(CMD_READ, '1, '1);
    add_item(CMD_DEQ,  '0, '0);
    add_item(CMD_DEQ,  '0, '0);
    add_item(CMD_DEQ,  '0, '0);

    // limit of zero: every enqueue is full
    write_cap(CAP_W'(0));
    @(negedge clk);
    add_item(CMD_ENQ,  32'h0000_0007, '0);
    add_item(CMD_READ, '0, '0);

    // full takes precedence over duplicate
    write_cap(CAP_W'(2));
    @(negedge clk);
    add_item(CMD_ENQ,  32'h1111_1111, '0);
    add_item(CMD_ENQ,  32'h2222_2222, '0);
    add_item(CMD_ENQ,  32'h3333_3333, '0);
    add_item(CMD_ENQ,  32'h1111_1111, '0);
    add_item(CMD_READ, '0, 4'd1);

    // limit lowered below the count: nothing dropped, full until drained
    write_cap(CAP_W'(1));
    @(negedge clk);
    add_item(CMD_ENQ,  32'h4444_4444, '0);
    add_item(CMD_DEQ,  '0, '0);
    add_item(CMD_ENQ,  32'h4444_4444, '0);
    add_item(CMD_DEQ,  '0, '0);
    add_item(CMD_ENQ,  32'h4444_4444, '0);
    add_item(CMD_DEQ,  '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      write_cap(phase_cap[ph]);
      @(negedge clk);
      no_idle = (ph == 0);
      hold_req = (ph == 1);
      gen_phase(95);
    end

    drain();
    if (n_errors == 0) begin
      $display("[dedup_fifo_queue] OK");
    end else begin
      $display("[dedup_fifo_queue] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[dedup_fifo_queue] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
